>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros shared by the checker files.
// Each macro takes a label, a clock and a property expression; OHS_ASSERT_RST also takes a reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define OHS_ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// Checked at every clock edge, reset included.
`define OHS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

>>> rtl/ohs_pkg.sv
// ----------------------------------------------------------------------------
// ohs_pkg
// Types and codes shared by the open-addressing hash set and its checker.
// ----------------------------------------------------------------------------
package ohs_pkg;

  localparam int KEY_W     = 31;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int CNT_OUT_W = 5;
  localparam int CFG_W     = 5;
  localparam int SLOTS_DEF = 16;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  // Slot tags.
  localparam logic [1:0] TAG_EMPTY   = 2'd0;
  localparam logic [1:0] TAG_USED    = 2'd1;
  localparam logic [1:0] TAG_DELETED = 2'd2;

  typedef struct packed {
    logic [1:0]       tag;
    logic [KEY_W-1:0] key;
  } slot_t;

endpackage

>>> rtl/ohs_mod.sv
// ----------------------------------------------------------------------------
// ohs_mod
// Multi-cycle remainder unit: key mod modulus, four quotient bits a cycle.
// ----------------------------------------------------------------------------
module ohs_mod (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ohs_pkg::KEY_W-1:0]  dividend,
  input  logic [ohs_pkg::CFG_W-1:0]  modulus,
  output logic                       done,
  output logic [ohs_pkg::CFG_W-1:0]  remainder
);

  localparam int KW    = ohs_pkg::KEY_W;
  localparam int MW    = ohs_pkg::CFG_W;
  localparam int STEPS = 4;
  localparam int PADW  = ((KW + STEPS - 1) / STEPS) * STEPS;
  localparam int ITERS = PADW / STEPS;
  localparam int NW    = (ITERS > 1) ? $clog2(ITERS) : 1;
  localparam logic [NW-1:0] LAST_ITER = NW'(ITERS - 1);

  logic            busy_r;
  logic            done_r;
  logic [NW-1:0]   cnt_r;
  logic [PADW-1:0] shift_r;
  logic [MW-1:0]   mod_r;
  logic [MW:0]     rem_r;
  logic [MW:0]     rem_nxt;

  // Restoring division: the running remainder stays below the modulus, so
  // one compare and subtract per quotient bit suffices.
  always_comb begin
    rem_nxt = rem_r;
    for (int s = 0; s < STEPS; s++) begin
      rem_nxt = {rem_nxt[MW-1:0], shift_r[PADW-1-s]};
      if (rem_nxt >= {1'b0, mod_r}) begin
        rem_nxt = rem_nxt - {1'b0, mod_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == LAST_ITER);
      if (start && !busy_r) begin
        busy_r  <= 1'b1;
        cnt_r   <= '0;
        shift_r <= PADW'(dividend);
        mod_r   <= modulus;
        rem_r   <= '0;
      end else if (busy_r) begin
        rem_r   <= rem_nxt;
        shift_r <= shift_r << STEPS;
        cnt_r   <= cnt_r + 1'b1;
        if (cnt_r == LAST_ITER) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r[MW-1:0];

endmodule

>>> rtl/open_addressing_hash_set.sv
// ----------------------------------------------------------------------------
// open_addressing_hash_set
// Set of 31-bit keys in a slot table, open addressing with linear probing.
// ----------------------------------------------------------------------------
// One request is handled at a time. A request passes through the remainder
// unit for the home slot (key mod modulus, four bits a cycle), the issue of
// the read of the home slot, the probe of 1 to the modulus slots in turn
// through the single read port of the slot memory, and the load of the
// output register. The next request is accepted in the cycle after the
// result is loaded. A request with the unused kind code skips the remainder
// unit and the probe and goes straight to the output register. The
// table write and the count update happen in the cycle that decides the
// request. The slot tags are cleared by reset through one valid flip-flop
// per slot, so no clearing pass is needed. The modulus is slots_in_use
// clamped to 1..SLOTS; at most 31 slots are reachable through the 5-bit
// register, and only those are built.
module open_addressing_hash_set #(
  parameter int SLOTS = ohs_pkg::SLOTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // in_tdata: key[30:0], zero [31]
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [31:0]               in_tdata,
  // in_tuser: kind[1:0]
  input  logic [1:0]                in_tuser,
  // out_tdata: status[1:0], element_count[6:2], zero [7]
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [7:0]                out_tdata,
  input  logic                      cfg_we,
  input  logic [ohs_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int KW    = ohs_pkg::KEY_W;
  localparam int MW    = ohs_pkg::CFG_W;
  localparam int SW    = ohs_pkg::STATUS_W;
  localparam int OUTW  = ohs_pkg::CNT_OUT_W;
  localparam int REACH = (1 << MW) - 1;
  localparam int DEPTH = (SLOTS < REACH) ? SLOTS : REACH;
  localparam int IW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam logic [MW-1:0] DEPTH_M = MW'(DEPTH);
  localparam logic [MW-1:0] ONE_M   = MW'(1);

  typedef enum logic [1:0] {S_IDLE, S_HASH, S_PROBE, S_OUT} state_t;

  state_t                    state_r;
  logic [MW-1:0]             cfg_r;
  logic [MW-1:0]             m_sel;
  logic [MW-1:0]             m_r;
  logic [ohs_pkg::KIND_W-1:0] kind_r;
  logic [KW-1:0]             key_r;
  logic [IW-1:0]             j_r;
  logic [IW-1:0]             j_nxt;
  logic [MW-1:0]             j_inc;
  logic [MW-1:0]             i_r;
  logic                      have_free_r;
  logic [IW-1:0]             free_at_r;
  logic [CW-1:0]             cnt_r;
  logic [SW-1:0]             res_status_r;
  logic                      out_valid_r;
  logic [SW-1:0]             out_status_r;
  logic [OUTW-1:0]           out_count_r;

  logic                      in_acc;
  logic                      div_done;
  logic [MW-1:0]             div_rem;

  // Slot memory and per-slot valid bits.
  ohs_pkg::slot_t            mem [DEPTH];
  logic [DEPTH-1:0]          vld_r;
  logic [IW-1:0]             rd_addr;
  ohs_pkg::slot_t            rd_q_r;
  logic                      rd_vld_r;

  // Probe decision.
  logic [1:0]                tag;
  logic                      hit;
  logic                      last;
  logic                      fin;
  logic [SW-1:0]             fin_status;
  logic                      wr_en;
  logic [IW-1:0]             wr_idx;
  logic [1:0]                wr_tag;
  logic                      cnt_inc;
  logic                      cnt_dec;
  logic                      have_free_nxt;
  logic [IW-1:0]             free_at_nxt;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    if (cfg_r == '0) begin
      m_sel = ONE_M;
    end else if (cfg_r > DEPTH_M) begin
      m_sel = DEPTH_M;
    end else begin
      m_sel = cfg_r;
    end
  end

  ohs_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_acc && (in_tuser != ohs_pkg::KIND_UNUSED)),
    .dividend  (in_tdata[KW-1:0]),
    .modulus   (m_sel),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign j_inc = MW'(j_r) + ONE_M;
  assign j_nxt = (j_inc == m_r) ? '0 : j_inc[IW-1:0];

  // The read for the next slot goes out while the current one is judged.
  assign rd_addr = (state_r == S_HASH) ? div_rem[IW-1:0] : j_nxt;

  assign tag  = rd_vld_r ? rd_q_r.tag : ohs_pkg::TAG_EMPTY;
  assign hit  = (tag == ohs_pkg::TAG_USED) && (rd_q_r.key == key_r);
  assign last = (i_r == (m_r - ONE_M));

  always_comb begin
    fin           = 1'b0;
    fin_status    = ohs_pkg::ST_ABSENT;
    wr_en         = 1'b0;
    wr_idx        = j_r;
    wr_tag        = ohs_pkg::TAG_USED;
    cnt_inc       = 1'b0;
    cnt_dec       = 1'b0;
    have_free_nxt = have_free_r;
    free_at_nxt   = free_at_r;
    case (kind_r) inside
      ohs_pkg::KIND_INSERT: begin
        if (hit) begin
          fin        = 1'b1;
          fin_status = ohs_pkg::ST_PRESENT;
        end else begin
          // Remember the first free slot, but keep probing to an empty one
          // so that a copy further along is still found.
          if (tag != ohs_pkg::TAG_USED && !have_free_r) begin
            have_free_nxt = 1'b1;
            free_at_nxt   = j_r;
          end
          if (tag == ohs_pkg::TAG_EMPTY || last) begin
            fin = 1'b1;
            if (have_free_nxt) begin
              fin_status = ohs_pkg::ST_DONE;
              wr_en      = 1'b1;
              wr_idx     = free_at_nxt;
              cnt_inc    = 1'b1;
            end else begin
              fin_status = ohs_pkg::ST_FULL;
            end
          end
        end
      end
      ohs_pkg::KIND_LOOKUP, ohs_pkg::KIND_REMOVE: begin
        if (tag == ohs_pkg::TAG_EMPTY) begin
          fin = 1'b1;
        end else if (hit) begin
          fin        = 1'b1;
          fin_status = ohs_pkg::ST_DONE;
          if (kind_r == ohs_pkg::KIND_REMOVE) begin
            wr_en   = 1'b1;
            wr_tag  = ohs_pkg::TAG_DELETED;
            cnt_dec = (cnt_r != '0);
          end
        end else if (last) begin
          fin = 1'b1;
        end
      end
      default: begin
        fin = 1'b1;
      end
    endcase
    if (state_r != S_PROBE) begin
      fin     = 1'b0;
      wr_en   = 1'b0;
      cnt_inc = 1'b0;
      cnt_dec = 1'b0;
    end
  end

  // Slot memory: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= '{tag: wr_tag, key: key_r};
    end
    rd_q_r   <= mem[rd_addr];
    rd_vld_r <= vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= ohs_pkg::CFG_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // In S_OUT the output register is refilled in the same cycle.
      if (out_valid_r && out_tready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      if (cnt_inc) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (cnt_dec) begin
        cnt_r <= cnt_r - 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            kind_r       <= in_tuser;
            key_r        <= in_tdata[KW-1:0];
            m_r          <= m_sel;
            res_status_r <= ohs_pkg::ST_ABSENT;
            state_r      <= (in_tuser == ohs_pkg::KIND_UNUSED) ? S_OUT : S_HASH;
          end
        end
        S_HASH: begin
          if (div_done) begin
            j_r         <= div_rem[IW-1:0];
            i_r         <= '0;
            have_free_r <= 1'b0;
            state_r     <= S_PROBE;
          end
        end
        S_PROBE: begin
          have_free_r <= have_free_nxt;
          free_at_r   <= free_at_nxt;
          if (fin) begin
            res_status_r <= fin_status;
            state_r      <= S_OUT;
          end else begin
            j_r <= j_nxt;
            i_r <= i_r + ONE_M;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_count_r  <= OUTW'(cnt_r);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_count_r, out_status_r};

endmodule

>>> rtl/ohs_checker.sv
// ----------------------------------------------------------------------------
// ohs_checker
// Port-level checks for the hash set, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ohs_checker #(
  parameter int SLOTS = ohs_pkg::SLOTS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  localparam int REACH = (1 << ohs_pkg::CFG_W) - 1;
  localparam int DEPTH = (SLOTS < REACH) ? SLOTS : REACH;
  localparam logic [ohs_pkg::CNT_OUT_W-1:0] MAX_CNT = ohs_pkg::CNT_OUT_W'(DEPTH);

  // Requests taken whose result has not yet been delivered.
  logic [1:0] pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {1'b0, in_tvalid && in_tready}
                       - {1'b0, out_tvalid && out_tready};
    end
  end

  `OHS_ASSERT_RST(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  `OHS_ASSERT_RST(a_no_spurious, clk, rst_n, out_tvalid |-> pend_r != 2'd0)
  `OHS_ASSERT_RST(a_one_in_flight, clk, rst_n, in_tvalid && in_tready |-> pend_r <= 2'd1)
  `OHS_ASSERT_RST(a_count_range, clk, rst_n, out_tvalid |-> out_tdata[6:2] <= MAX_CNT)
  `OHS_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_tvalid)

endmodule

bind open_addressing_hash_set ohs_checker #(.SLOTS(SLOTS)) u_ohs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the open-addressing hash set. A table of directed requests
// covers the extreme keys, every request kind, clashes, deleted slots, a full
// table and modulus values out of range. Phases of random requests follow,
// drawn mostly from a small pool of keys so that probes collide, the table
// fills and removals leave deleted marks. Results are checked against the
// typed row values, else a shadow of the slot table kept by the testbench.
// ----------------------------------------------------------------------------
module tb;

  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 135;

  typedef struct packed {
    logic [ohs_pkg::STATUS_W-1:0]  status;
    logic [ohs_pkg::CNT_OUT_W-1:0] count;
  } set_result_t;

  typedef struct packed {
    logic                          is_cfg;
    logic [ohs_pkg::CFG_W-1:0]     cfg;
    logic [ohs_pkg::KIND_W-1:0]    kind;
    logic [ohs_pkg::KEY_W-1:0]     key;
    logic                          typed;
    logic [ohs_pkg::STATUS_W-1:0]  status;
    logic [ohs_pkg::CNT_OUT_W-1:0] count;
  } stim_row_t;

  logic                       clk        = 1'b0;
  logic                       rst_n      = 1'b0;
  logic                       in_tvalid  = 1'b0;
  logic                       in_tready;
  logic [31:0]                in_tdata   = '0;
  logic [1:0]                 in_tuser   = '0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [7:0]                 out_tdata;
  logic                       cfg_we     = 1'b0;
  logic [ohs_pkg::CFG_W-1:0]  cfg_wdata  = '0;

  // Shadow of the block's state.
  logic [1:0]                 shadow_tag [ohs_pkg::SLOTS_DEF];
  logic [ohs_pkg::KEY_W-1:0]  shadow_key [ohs_pkg::SLOTS_DEF];
  int                         shadow_count;
  logic [ohs_pkg::CFG_W-1:0]  shadow_slots;

  set_result_t                pending_results [$];
  stim_row_t                  directed_rows [$];
  logic [ohs_pkg::KEY_W-1:0]  key_pool [$];
  int                         mismatch_count = 0;
  int                         send_idle_pct  = 0;
  int                         recv_stall_pct = 0;

  always #4 clk = ~clk;

  open_addressing_hash_set DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic int active_modulus();
    if (shadow_slots == 0) return 1;
    if (shadow_slots > ohs_pkg::SLOTS_DEF) return ohs_pkg::SLOTS_DEF;
    return int'(shadow_slots);
  endfunction

  // Returns the slot holding key, or -1; the probe stops at an empty slot.
  function automatic int locate_key(input logic [ohs_pkg::KEY_W-1:0] key, input int m);
    int j;
    int i;
    j = int'(key % 31'(m));
    for (i = 0; i < m; i++) begin
      if (shadow_tag[j] == ohs_pkg::TAG_EMPTY) return -1;
      if (shadow_tag[j] == ohs_pkg::TAG_USED && shadow_key[j] == key) return j;
      j = (j + 1 == m) ? 0 : j + 1;
    end
    return -1;
  endfunction

  function automatic set_result_t apply_request(input logic [ohs_pkg::KIND_W-1:0] kind,
                                                input logic [ohs_pkg::KEY_W-1:0] key);
    set_result_t r;
    int m;
    int j;
    int i;
    int free_at;
    bit have_free;
    bit found;
    m = active_modulus();
    r.status = ohs_pkg::ST_ABSENT;
    case (kind)
      ohs_pkg::KIND_INSERT: begin
        // Probe on past deleted slots so that a key further along is seen.
        j = int'(key % 31'(m));
        have_free = 1'b0;
        found = 1'b0;
        free_at = 0;
        for (i = 0; i < m; i++) begin
          if (shadow_tag[j] == ohs_pkg::TAG_USED) begin
            if (shadow_key[j] == key) begin
              found = 1'b1;
              break;
            end
          end else begin
            if (!have_free) begin
              have_free = 1'b1;
              free_at = j;
            end
            if (shadow_tag[j] == ohs_pkg::TAG_EMPTY) break;
          end
          j = (j + 1 == m) ? 0 : j + 1;
        end
        if (found) begin
          r.status = ohs_pkg::ST_PRESENT;
        end else if (!have_free) begin
          r.status = ohs_pkg::ST_FULL;
        end else begin
          shadow_key[free_at] = key;
          shadow_tag[free_at] = ohs_pkg::TAG_USED;
          shadow_count++;
          r.status = ohs_pkg::ST_DONE;
        end
      end
      ohs_pkg::KIND_LOOKUP: begin
        if (locate_key(key, m) >= 0) r.status = ohs_pkg::ST_DONE;
      end
      ohs_pkg::KIND_REMOVE: begin
        j = locate_key(key, m);
        if (j >= 0) begin
          shadow_tag[j] = ohs_pkg::TAG_DELETED;
          if (shadow_count > 0) shadow_count--;
          r.status = ohs_pkg::ST_DONE;
        end
      end
      default: r.status = ohs_pkg::ST_ABSENT;
    endcase
    r.count = shadow_count[ohs_pkg::CNT_OUT_W-1:0];
    return r;
  endfunction

  task automatic send_request(input logic [ohs_pkg::KIND_W-1:0] kind,
                              input logic [ohs_pkg::KEY_W-1:0] key,
                              input bit typed, input set_result_t typed_result);
    set_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, key};
    in_tuser  <= kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = apply_request(kind, key);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_slots_in_use(input logic [ohs_pkg::CFG_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_slots = value;
  endtask

  task automatic row_cfg(input logic [ohs_pkg::CFG_W-1:0] value);
    directed_rows.push_back('{is_cfg: 1'b1, cfg: value, kind: '0, key: '0,
                              typed: 1'b0, status: '0, count: '0});
  endtask

  task automatic row_req(input logic [ohs_pkg::KIND_W-1:0] kind,
                         input logic [ohs_pkg::KEY_W-1:0] key,
                         input bit typed, input logic [ohs_pkg::STATUS_W-1:0] status,
                         input logic [ohs_pkg::CNT_OUT_W-1:0] count);
    directed_rows.push_back('{is_cfg: 1'b0, cfg: '0, kind: kind, key: key,
                              typed: typed, status: status, count: count});
  endtask

  // Result side: random back-pressure and the comparison with the oldest request.
  always @(posedge clk) begin
    set_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result 0x%02h with no request outstanding", out_tdata));
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[1:0] !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_tdata[1:0],
                                    want.status));
        if (out_tdata[6:2] !== want.count)
          report_mismatch($sformatf("element_count %0d, expected %0d", out_tdata[6:2],
                                    want.count));
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [ohs_pkg::CFG_W-1:0] phase_cfg [PHASES];
    stim_row_t row;
    logic [ohs_pkg::KEY_W-1:0] key;
    logic [ohs_pkg::KIND_W-1:0] kind;
    int pool_size;
    int pause_at;
    int pick;
    int p;
    int n;

    for (n = 0; n < ohs_pkg::SLOTS_DEF; n++) begin
      shadow_tag[n] = ohs_pkg::TAG_EMPTY;
      shadow_key[n] = '0;
    end
    shadow_count = 0;
    shadow_slots = ohs_pkg::CFG_RESET;

    // Modulus 16 at reset.
    row_req(ohs_pkg::KIND_LOOKUP, 31'd0,          1, ohs_pkg::ST_ABSENT,  5'd0);
    row_req(ohs_pkg::KIND_REMOVE, 31'h7FFF_FFFF,  1, ohs_pkg::ST_ABSENT,  5'd0);
    row_req(ohs_pkg::KIND_UNUSED, 31'd5,          1, ohs_pkg::ST_ABSENT,  5'd0);
    row_req(ohs_pkg::KIND_INSERT, 31'd0,          1, ohs_pkg::ST_DONE,    5'd1);
    row_req(ohs_pkg::KIND_INSERT, 31'd0,          1, ohs_pkg::ST_PRESENT, 5'd1);
    row_req(ohs_pkg::KIND_INSERT, 31'h7FFF_FFFF,  1, ohs_pkg::ST_DONE,    5'd2);
    row_req(ohs_pkg::KIND_INSERT, 31'd16,         1, ohs_pkg::ST_DONE,    5'd3);
    row_req(ohs_pkg::KIND_REMOVE, 31'd0,          1, ohs_pkg::ST_DONE,    5'd2);
    row_req(ohs_pkg::KIND_LOOKUP, 31'd16,         1, ohs_pkg::ST_DONE,    5'd2);
    // The key sits past a deleted slot, so the insert must find it.
    row_req(ohs_pkg::KIND_INSERT, 31'd16,         1, ohs_pkg::ST_PRESENT, 5'd2);
    row_req(ohs_pkg::KIND_INSERT, 31'd32,         1, ohs_pkg::ST_DONE,    5'd3);
    row_req(ohs_pkg::KIND_UNUSED, 31'h7FFF_FFFF,  1, ohs_pkg::ST_ABSENT,  5'd3);
    // A single slot: full table, reuse of a deleted slot, keys out of reach.
    row_cfg(5'd1);
    row_req(ohs_pkg::KIND_INSERT, 31'd5,          1, ohs_pkg::ST_FULL,    5'd3);
    row_req(ohs_pkg::KIND_LOOKUP, 31'd32,         0, ohs_pkg::ST_DONE,    5'd3);
    row_req(ohs_pkg::KIND_REMOVE, 31'd32,         1, ohs_pkg::ST_DONE,    5'd2);
    row_req(ohs_pkg::KIND_INSERT, 31'd5,          1, ohs_pkg::ST_DONE,    5'd3);
    row_req(ohs_pkg::KIND_LOOKUP, 31'd16,         1, ohs_pkg::ST_ABSENT,  5'd3);
    // Zero acts as one slot.
    row_cfg(5'd0);
    row_req(ohs_pkg::KIND_LOOKUP, 31'd5,          1, ohs_pkg::ST_DONE,    5'd3);
    row_req(ohs_pkg::KIND_INSERT, 31'd6,          1, ohs_pkg::ST_FULL,    5'd3);
    // Values above the table size act as the full table.
    row_cfg(5'd31);
    row_req(ohs_pkg::KIND_LOOKUP, 31'd16,         1, ohs_pkg::ST_DONE,    5'd3);
    row_req(ohs_pkg::KIND_LOOKUP, 31'h7FFF_FFFF,  0, ohs_pkg::ST_DONE,    5'd3);
    row_req(ohs_pkg::KIND_REMOVE, 31'h7FFF_FFFF,  0, ohs_pkg::ST_DONE,    5'd2);
    row_req(ohs_pkg::KIND_INSERT, 31'h5555_5555,  0, ohs_pkg::ST_DONE,    5'd3);
    row_req(ohs_pkg::KIND_INSERT, 31'h2AAA_AAAA,  0, ohs_pkg::ST_DONE,    5'd4);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[n]) begin
      row = directed_rows[n];
      if (row.is_cfg)
        write_slots_in_use(row.cfg);
      else
        send_request(row.kind, row.key, row.typed, '{status: row.status, count: row.count});
    end

    phase_cfg = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd0, 5'd9, 5'd17, 5'd16};
    phase_cfg[PHASES-1] = ohs_pkg::CFG_W'($urandom_range(0, 31));

    for (p = 0; p < PHASES; p++) begin
      write_slots_in_use(phase_cfg[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase

      // A small pool of keys makes probes clash and lets the table fill.
      key_pool.delete();
      pool_size = $urandom_range(4, 24);
      for (n = 0; n < pool_size; n++) begin
        case ($urandom_range(2))
          0:       key = ohs_pkg::KEY_W'($urandom);
          1:       key = ohs_pkg::KEY_W'($urandom_range(0, 40));
          default: key = 31'h7FFF_FFFF - ohs_pkg::KEY_W'($urandom_range(0, 40));
        endcase
        key_pool.push_back(key);
      end

      pause_at = $urandom_range(10, PHASE_ITEMS - 10);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n == pause_at) wait_drained();
        if ($urandom_range(99) < 10)
          key = ohs_pkg::KEY_W'($urandom);
        else
          key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        pick = $urandom_range(99);
        if (pick < 45)      kind = ohs_pkg::KIND_INSERT;
        else if (pick < 70) kind = ohs_pkg::KIND_LOOKUP;
        else if (pick < 94) kind = ohs_pkg::KIND_REMOVE;
        else                kind = ohs_pkg::KIND_UNUSED;
        send_request(kind, key, 0, '0);
      end
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
